// ----- rtl/core/rhc_pkg.sv -----
package rhc_pkg;

   localparam int HUE_W = 16;
   localparam int SQ_W  = 13;
   localparam int LVL_W = 10;

   localparam logic [SQ_W-1:0] Q12_ONE = 13'd4096;
   localparam int DEG_FULL   = 360;
   localparam int DEG_SECTOR = 60;

   // 60 * 4096, the unit of the mode 1 fraction terms
   localparam logic [17:0] Q_ONE60 = 18'd245760;

   // ceil(2^30 / 60), exact quotient for dividends below 2^24
   localparam logic [24:0] RECIP60     = 25'd17895698;
   localparam int          RECIP_SHIFT = 30;
   localparam int          SCALE_SHIFT = 24;

   // ceil(2^32 / 360), exact quotient for 16 bit dividends
   localparam logic [23:0] RECIP360  = 24'd11930465;
   localparam int          MOD_SHIFT = 32;

   localparam logic MODE_RGB = 1'b0;
   localparam logic MODE_HSV = 1'b1;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef enum logic [2:0] {
      SECTOR_0,
      SECTOR_1,
      SECTOR_2,
      SECTOR_3,
      SECTOR_4,
      SECTOR_5
   } sector_type;

   typedef struct packed {
      logic              mode;
      logic [HUE_W-1:0]  hue;
      logic [SQ_W-1:0]   sat;
      logic [SQ_W-1:0]   val;
   } hsv_side_type;

   typedef struct packed {
      max_sel_type sel;
      logic        neg;
      logic        dz;
      sector_type  sector;
   } hue_ctl_type;

   typedef struct packed {
      logic              mode;
      logic [HUE_W-1:0]  red_in;
      logic [HUE_W-1:0]  green_in;
      logic [HUE_W-1:0]  blue_in;
      logic [HUE_W-1:0]  hue_in;
      logic [SQ_W-1:0]   sat_in;
      logic [SQ_W-1:0]   val_in;
   } req_type;

   typedef struct packed {
      logic [LVL_W-1:0]  level_red;
      logic [LVL_W-1:0]  level_green;
      logic [LVL_W-1:0]  level_blue;
      logic [HUE_W-1:0]  hue_out;
      logic [SQ_W-1:0]   sat_out;
      logic [SQ_W-1:0]   val_out;
      logic [LVL_W-1:0]  drive_red;
      logic [LVL_W-1:0]  drive_green;
      logic [LVL_W-1:0]  drive_blue;
   } rsp_type;

endpackage

// ----- rtl/core/rhc_div.sv -----
module rhc_div #(
   parameter int LANES = 3,
   parameter int NW    = 16,
   parameter int DW    = 17,
   parameter int QW    = 8,
   parameter int SW    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [LANES-1:0][NW-1:0]      in_num,
   input  logic [LANES-1:0][DW-1:0]      in_den,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [LANES-1:0][QW-1:0]      out_quot,
   output logic [LANES-1:0][DW-1:0]      out_rem,
   output logic [SW-1:0]                 out_side
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic                         vld_ff  [QW];
   logic [LANES-1:0][NW-1:0]     rem_ff  [QW];
   logic [LANES-1:0][DW-1:0]     den_ff  [QW];
   logic [LANES-1:0][QW-1:0]     quot_ff [QW];
   logic [SW-1:0]                side_ff [QW];
   logic                         rdy     [QW+1];

   assign rdy[QW] = !out_stall;

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                      v_src;
      logic [LANES-1:0][NW-1:0]  r_src;
      logic [LANES-1:0][DW-1:0]  d_src;
      logic [LANES-1:0][QW-1:0]  q_src;
      logic [SW-1:0]             s_src;
      logic [LANES-1:0][NW-1:0]  rem_in;
      logic [LANES-1:0][QW-1:0]  quot_in;
      logic [LANES-1:0][CW-1:0]  trial;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = in_num;
         assign d_src = in_den;
         assign q_src = '0;
         assign s_src = in_side;
      end else begin : g_next
         assign v_src = vld_ff[k-1];
         assign r_src = rem_ff[k-1];
         assign d_src = den_ff[k-1];
         assign q_src = quot_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]   = CW'(d_src[l]) << (QW - 1 - k);
            rem_in[l]  = r_src[l];
            quot_in[l] = q_src[l];
            if (CW'(r_src[l]) >= trial[l]) begin
               rem_in[l]             = NW'(CW'(r_src[l]) - trial[l]);
               quot_in[l][QW-1-k]    = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= v_src;
         end
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= d_src;
            quot_ff[k] <= quot_in;
            side_ff[k] <= s_src;
         end
      end
   end

   assign in_stall  = !rdy[0];
   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_rem[l] = DW'(rem_ff[QW-1][l]);
      end
   end

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (DW'(rem_ff[QW-1][0]) < den_ff[QW-1][0]))
      else $error("divider remainder not below divisor");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && $stable(out_quot))
      else $error("divider result lost under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid)
      else $error("divider not empty after reset");
`endif

endmodule

// ----- rtl/core/rhc_prep.sv -----
module rhc_prep import rhc_pkg::*; #(
   parameter int PWM_MAX = 1023
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_stall,
   input  logic [3:0][HUE_W-1:0]                   in_raw,
   input  hsv_side_type                            in_hsv,
   output logic                                    out_valid,
   input  logic                                    out_stall,
   output logic [1:0][$clog2(PWM_MAX+1)+11:0]      out_num,
   output logic [1:0][$clog2(PWM_MAX+1):0]         out_den,
   output logic [2:0][$clog2(PWM_MAX+1)-1:0]       out_lvl,
   output logic [3:0][$clog2(PWM_MAX+1)-1:0]       out_term,
   output logic [SQ_W-1:0]                         out_val,
   output hue_ctl_type                             out_ctl,
   output hsv_side_type                            out_hsv
);

   localparam int LW  = $clog2(PWM_MAX + 1);
   localparam int NNW = LW + 6;
   localparam int AW  = 19;
   localparam int CQW = 30;
   localparam int CPW = 25;
   localparam int EQW = CQW + LW;
   localparam int EPW = CPW + LW;
   localparam int EVW = SQ_W + LW;
   localparam int YW  = EQW - SCALE_SHIFT;
   localparam int PQW = YW + 25;
   localparam int QRW = 8;
   localparam int MPW = HUE_W + 25;
   localparam int RMW = HUE_W + 1;
   localparam int VSH = 2 * LW + 12;
   localparam int VPW = 2 * LW + 26;

   // ceil(2^32 / (PWM_MAX+1)), exact quotient for 16 bit requests
   localparam logic [24:0] RECIP_LVL =
      25'(((64'd1 << MOD_SHIFT) + 64'(PWM_MAX)) / 64'(PWM_MAX + 1));
   // ceil(2^VSH / PWM_MAX), exact quotient for mx * 4096
   localparam logic [LW+13:0] RECIP_VAL =
      (LW + 14)'(((64'd1 << VSH) + 64'(PWM_MAX) - 64'd1) / 64'(PWM_MAX));

   // common fields carried through stages 1 to 5
   typedef struct packed {
      hsv_side_type            hsv;
      logic [2:0][LW-1:0]      lvl;
      logic [LW-1:0]           mx;
      logic [LW-1:0]           d;
      logic                    neg;
      max_sel_type             sel;
      sector_type              sector;
   } carry_type;

   logic rdy_r1, rdy_r2;
   logic r1_vld_ff, r2_vld_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;

   logic [3:0][HUE_W-1:0] r1_raw_ff;
   logic [3:0][QRW-1:0]   r1_quot_ff, quot_in;
   hsv_side_type          r1_hsv_ff, r2_hsv_ff;
   logic [2:0][LW-1:0]    r2_lvl_ff, lvl_in;
   logic [8:0]            r2_hue_ff, hue_rem_in;

   carry_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   carry_type s1_in;

   logic [LW-1:0]  s1_absd_ff, absd_in;
   logic [5:0]     s1_fr_ff, fr_in;
   logic [NNW-1:0] s2_n60_ff, s3_n60_ff, s4_n60_ff, s5_n60_ff;
   logic [AW-1:0]  s2_aq_ff, s2_at_ff;
   logic [VPW-1:0] s2_vp_ff;
   logic [CQW-1:0] s3_cq_ff, s3_ct_ff;
   logic [CPW-1:0] s3_cp_ff;
   logic [SQ_W-1:0] s3_val_ff, s4_val_ff, s5_val_ff;
   logic [EQW-1:0] s4_eq_ff, s4_et_ff;
   logic [EPW-1:0] s4_ep_ff;
   logic [EVW-1:0] s4_ev_ff;
   logic [PQW-1:0] s5_pq_ff, s5_pt_ff;
   logic [LW-1:0]  s5_tp_ff, s5_tv_ff;

   logic [LW:0]    diff;
   logic [8:0]     base;
   logic [5:0]     fr_c;

   assign rdy5 = !s5_vld_ff || !out_stall;
   assign rdy4 = !s4_vld_ff || rdy5;
   assign rdy3 = !s3_vld_ff || rdy4;
   assign rdy2 = !s2_vld_ff || rdy3;
   assign rdy1 = !s1_vld_ff || rdy2;
   assign rdy_r2 = !r2_vld_ff || rdy1;
   assign rdy_r1 = !r1_vld_ff || rdy_r2;
   assign in_stall = !rdy_r1;

   // reduction stage 1: quotients through reciprocals
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         quot_in[l] = QRW'((MPW'(in_raw[l]) * MPW'(RECIP_LVL)) >> MOD_SHIFT);
      end
      quot_in[3] = QRW'((MPW'(in_raw[3]) * MPW'(RECIP360)) >> MOD_SHIFT);
   end

   // reduction stage 2: remainders
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lvl_in[l] = LW'(RMW'(r1_raw_ff[l]) - RMW'(r1_quot_ff[l]) * RMW'(PWM_MAX + 1));
      end
      hue_rem_in = 9'(RMW'(r1_raw_ff[3]) - RMW'(r1_quot_ff[3]) * RMW'(DEG_FULL));
   end

   // stage 1: max, min, hue difference, hue sector
   always_comb begin
      s1_in.hsv = r2_hsv_ff;
      s1_in.lvl = r2_lvl_ff;
      s1_in.mx  = r2_lvl_ff[0];
      if (r2_lvl_ff[1] > s1_in.mx) s1_in.mx = r2_lvl_ff[1];
      if (r2_lvl_ff[2] > s1_in.mx) s1_in.mx = r2_lvl_ff[2];
      s1_in.d = r2_lvl_ff[0];
      if (r2_lvl_ff[1] < s1_in.d) s1_in.d = r2_lvl_ff[1];
      if (r2_lvl_ff[2] < s1_in.d) s1_in.d = r2_lvl_ff[2];
      s1_in.d = s1_in.mx - s1_in.d;
      if (s1_in.mx == r2_lvl_ff[0]) begin
         s1_in.sel = MAX_RED;
         diff      = {1'b0, r2_lvl_ff[1]} - {1'b0, r2_lvl_ff[2]};
      end else if (s1_in.mx == r2_lvl_ff[1]) begin
         s1_in.sel = MAX_GREEN;
         diff      = {1'b0, r2_lvl_ff[2]} - {1'b0, r2_lvl_ff[0]};
      end else begin
         s1_in.sel = MAX_BLUE;
         diff      = {1'b0, r2_lvl_ff[0]} - {1'b0, r2_lvl_ff[1]};
      end
      s1_in.neg = diff[LW];
      absd_in   = diff[LW] ? LW'(-diff) : LW'(diff);

      if (r2_hue_ff >= 9'd300) begin
         s1_in.sector = SECTOR_5;
         base         = 9'd300;
      end else if (r2_hue_ff >= 9'd240) begin
         s1_in.sector = SECTOR_4;
         base         = 9'd240;
      end else if (r2_hue_ff >= 9'd180) begin
         s1_in.sector = SECTOR_3;
         base         = 9'd180;
      end else if (r2_hue_ff >= 9'd120) begin
         s1_in.sector = SECTOR_2;
         base         = 9'd120;
      end else if (r2_hue_ff >= 9'd60) begin
         s1_in.sector = SECTOR_1;
         base         = 9'd60;
      end else begin
         s1_in.sector = SECTOR_0;
         base         = 9'd0;
      end
      fr_in = 6'(r2_hue_ff - base);
   end

   assign fr_c = 6'(DEG_SECTOR) - s1_fr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
         r2_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (rdy_r1) r1_vld_ff <= in_valid;
         if (rdy_r2) r2_vld_ff <= r1_vld_ff;
         if (rdy1) s1_vld_ff <= r2_vld_ff;
         if (rdy2) s2_vld_ff <= s1_vld_ff;
         if (rdy3) s3_vld_ff <= s2_vld_ff;
         if (rdy4) s4_vld_ff <= s3_vld_ff;
         if (rdy5) s5_vld_ff <= s4_vld_ff;
      end

      if (rdy_r1) begin
         r1_raw_ff  <= in_raw;
         r1_quot_ff <= quot_in;
         r1_hsv_ff  <= in_hsv;
      end

      if (rdy_r2) begin
         r2_lvl_ff <= lvl_in;
         r2_hue_ff <= hue_rem_in;
         r2_hsv_ff <= r1_hsv_ff;
      end

      if (rdy1) begin
         s1_ff      <= s1_in;
         s1_absd_ff <= absd_in;
         s1_fr_ff   <= fr_in;
      end

      // stage 2: s*f and s*(1-f), 60*|diff|, mx*4096 times reciprocal of PWM_MAX
      if (rdy2) begin
         s2_ff     <= s1_ff;
         s2_n60_ff <= NNW'(s1_absd_ff) * NNW'(DEG_SECTOR);
         s2_aq_ff  <= AW'(s1_ff.hsv.sat) * AW'(s1_fr_ff);
         s2_at_ff  <= AW'(s1_ff.hsv.sat) * AW'(fr_c);
         s2_vp_ff  <= VPW'({s1_ff.mx, 12'd0}) * VPW'(RECIP_VAL);
      end

      // stage 3: v times the fraction terms
      if (rdy3) begin
         s3_ff     <= s2_ff;
         s3_n60_ff <= s2_n60_ff;
         s3_cq_ff  <= CQW'(s2_ff.hsv.val) * CQW'(Q_ONE60 - 18'(s2_aq_ff));
         s3_ct_ff  <= CQW'(s2_ff.hsv.val) * CQW'(Q_ONE60 - 18'(s2_at_ff));
         s3_cp_ff  <= CPW'(s2_ff.hsv.val) * CPW'(Q12_ONE - s2_ff.hsv.sat);
         s3_val_ff <= SQ_W'(s2_vp_ff >> VSH);
      end

      // stage 4: scale to the pwm range
      if (rdy4) begin
         s4_ff     <= s3_ff;
         s4_n60_ff <= s3_n60_ff;
         s4_eq_ff  <= EQW'(s3_cq_ff) * EQW'(PWM_MAX);
         s4_et_ff  <= EQW'(s3_ct_ff) * EQW'(PWM_MAX);
         s4_ep_ff  <= EPW'(s3_cp_ff) * EPW'(PWM_MAX);
         s4_ev_ff  <= EVW'(s3_ff.hsv.val) * EVW'(PWM_MAX);
         s4_val_ff <= s3_val_ff;
      end

      // stage 5: divide by 60 through the reciprocal
      if (rdy5) begin
         s5_ff     <= s4_ff;
         s5_n60_ff <= s4_n60_ff;
         s5_pq_ff  <= PQW'(YW'(s4_eq_ff >> SCALE_SHIFT)) * PQW'(RECIP60);
         s5_pt_ff  <= PQW'(YW'(s4_et_ff >> SCALE_SHIFT)) * PQW'(RECIP60);
         s5_tp_ff  <= LW'(s4_ep_ff >> SCALE_SHIFT);
         s5_tv_ff  <= LW'(s4_ev_ff >> 12);
         s5_val_ff <= s4_val_ff;
      end
   end

   assign out_valid = s5_vld_ff;

   // lane 0 hue fraction, lane 1 saturation
   always_comb begin
      out_num[0] = (LW + 12)'(s5_n60_ff);
      out_num[1] = {s5_ff.d, 12'd0};
      out_den[0] = (s5_ff.d == '0) ? (LW + 1)'(1) : (LW + 1)'(s5_ff.d);
      out_den[1] = (s5_ff.mx == '0) ? (LW + 1)'(1) : (LW + 1)'(s5_ff.mx);
      out_lvl     = s5_ff.lvl;
      out_term[0] = s5_tv_ff;
      out_term[1] = s5_tp_ff;
      out_term[2] = LW'(s5_pq_ff >> RECIP_SHIFT);
      out_term[3] = LW'(s5_pt_ff >> RECIP_SHIFT);
      out_val     = s5_val_ff;
      out_ctl.sel    = s5_ff.sel;
      out_ctl.neg    = s5_ff.neg;
      out_ctl.dz     = (s5_ff.d == '0);
      out_ctl.sector = s5_ff.sector;
      out_hsv        = s5_ff.hsv;
   end

endmodule

// ----- rtl/core/rhc_post.sv -----
module rhc_post import rhc_pkg::*; #(
   parameter int PWM_MAX = 1023
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  inverted,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic [2:0][SQ_W-1:0]                  in_quot,
   input  logic [$clog2(PWM_MAX+1):0]            in_hue_rem,
   input  logic [2:0][$clog2(PWM_MAX+1)-1:0]     in_lvl,
   input  logic [3:0][$clog2(PWM_MAX+1)-1:0]     in_term,
   input  hue_ctl_type                           in_ctl,
   input  hsv_side_type                          in_hsv,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output rsp_type                               out_data
);

   localparam int LW = $clog2(PWM_MAX + 1);
   localparam logic [LW-1:0] PMAX = LW'(PWM_MAX);

   logic          vld_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rdy;
   logic [8:0]    q9, base, hue9;
   logic          remnz;
   logic [LW-1:0] tv, tp, tq, tt;
   logic [2:0][LW-1:0] lvl;

   assign rdy      = !vld_ff || !out_stall;
   assign in_stall = !rdy;

   always_comb begin
      q9    = 9'(in_quot[0]);
      remnz = (in_hue_rem != '0);
      case (in_ctl.sel)
         MAX_RED:   base = 9'd0;
         MAX_GREEN: base = 9'd120;
         MAX_BLUE:  base = 9'd240;
         default:   base = 9'd0;
      endcase
      // truncation toward zero, wrap for a negative red hue
      if (in_ctl.dz) begin
         hue9 = 9'd0;
      end else if (!in_ctl.neg) begin
         hue9 = base + q9;
      end else if (in_ctl.sel == MAX_RED) begin
         hue9 = (q9 == 9'd0) ? 9'd0 : 9'(DEG_FULL) - q9;
      end else begin
         hue9 = base - q9 - 9'(remnz);
      end

      tv = in_term[0];
      tp = in_term[1];
      tq = in_term[2];
      tt = in_term[3];

      if (in_hsv.mode == MODE_RGB) begin
         lvl = in_lvl;
         rsp_in.hue_out = HUE_W'(hue9);
         rsp_in.sat_out = in_quot[1];
         rsp_in.val_out = in_quot[2];
      end else begin
         case (in_ctl.sector)
            SECTOR_0: lvl = {tp, tt, tv};
            SECTOR_1: lvl = {tp, tv, tq};
            SECTOR_2: lvl = {tt, tv, tp};
            SECTOR_3: lvl = {tv, tq, tp};
            SECTOR_4: lvl = {tv, tp, tt};
            default:  lvl = {tq, tp, tv};
         endcase
         rsp_in.hue_out = in_hsv.hue;
         rsp_in.sat_out = in_hsv.sat;
         rsp_in.val_out = in_hsv.val;
      end

      rsp_in.level_red   = LVL_W'(lvl[0]);
      rsp_in.level_green = LVL_W'(lvl[1]);
      rsp_in.level_blue  = LVL_W'(lvl[2]);
      rsp_in.drive_red   = inverted ? LVL_W'(PMAX - lvl[0]) : LVL_W'(lvl[0]);
      rsp_in.drive_green = inverted ? LVL_W'(PMAX - lvl[1]) : LVL_W'(lvl[1]);
      rsp_in.drive_blue  = inverted ? LVL_W'(PMAX - lvl[2]) : LVL_W'(lvl[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (rdy) begin
         vld_ff <= in_valid;
      end
      if (rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- rtl/core/rgb_hsv_led_color_converter.sv -----
// pipeline from an accepted req transfer to rsp_valid
// (2 reduction stages, 5 prep stages, 13 divider stages, 1 output register)
// throughput: one transfer per cycle while rsp is not stalled, every stage carries its own valid bit
// a stalled rsp only holds the stages it blocks; empty stages keep filling
// reset is synchronous, active high: clears all valid bits and inverted
module rgb_hsv_led_color_converter import rhc_pkg::*; #(
   parameter int PWM_MAX = 1023
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int LW     = $clog2(PWM_MAX + 1);
   localparam int DW     = LW + 1;
   localparam int SW_B   = 7 * LW + SQ_W + $bits(hue_ctl_type) + $bits(hsv_side_type);
   localparam int REG_INVERTED = 0;

   // config register, active-low leds
   logic inverted_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverted_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   (32'(paddr[2]) == REG_INVERTED)) begin
         inverted_ff <= pwdata[0];
      end
   end

   assign prdata = (32'(paddr[2]) == REG_INVERTED) ? {31'd0, inverted_ff} : 32'd0;

   // front end: clamp s and v; rgb and hue reduction happen in prep
   hsv_side_type              a_side_in;
   logic [3:0][HUE_W-1:0]     a_num;

   always_comb begin
      a_side_in.mode = req_data.mode;
      a_side_in.hue  = req_data.hue_in;
      a_side_in.sat  = (req_data.sat_in > Q12_ONE) ? Q12_ONE : req_data.sat_in;
      a_side_in.val  = (req_data.val_in > Q12_ONE) ? Q12_ONE : req_data.val_in;
      a_num[0] = req_data.red_in;
      a_num[1] = req_data.green_in;
      a_num[2] = req_data.blue_in;
      a_num[3] = req_data.hue_in;
   end

   // prep: reductions by reciprocal, max/min and hue sector, value scaling,
   // mode 1 products through reciprocal of 60
   logic                      p_valid, p_stall;
   logic [1:0][LW+11:0]       p_num;
   logic [1:0][DW-1:0]        p_den;
   logic [2:0][LW-1:0]        p_lvl;
   logic [3:0][LW-1:0]        p_term;
   logic [SQ_W-1:0]           p_val;
   hue_ctl_type               p_ctl;
   hsv_side_type              p_hsv;

   rhc_prep #(
      .PWM_MAX (PWM_MAX)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_raw     (a_num),
      .in_hsv     (a_side_in),
      .out_valid  (p_valid),
      .out_stall  (p_stall),
      .out_num    (p_num),
      .out_den    (p_den),
      .out_lvl    (p_lvl),
      .out_term   (p_term),
      .out_val    (p_val),
      .out_ctl    (p_ctl),
      .out_hsv    (p_hsv)
   );

   // main divider: hue fraction and saturation; everything else rides along
   logic [SW_B-1:0]           b_side_in, b_side_out;
   logic                      b_valid, b_stall;
   logic [1:0][SQ_W-1:0]      b_quot;
   logic [1:0][DW-1:0]        b_rem;
   logic [2:0][LW-1:0]        b_lvl;
   logic [3:0][LW-1:0]        b_term;
   logic [SQ_W-1:0]           b_val;
   hue_ctl_type               b_ctl;
   hsv_side_type              b_hsv;

   assign b_side_in = {p_lvl, p_term, p_val, p_ctl, p_hsv};
   assign {b_lvl, b_term, b_val, b_ctl, b_hsv} = b_side_out;

   rhc_div #(
      .LANES (2),
      .NW    (LW + 12),
      .DW    (DW),
      .QW    (SQ_W),
      .SW    (SW_B)
   ) u_div_hsv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_stall  (p_stall),
      .in_num    (p_num),
      .in_den    (p_den),
      .in_side   (b_side_in),
      .out_valid (b_valid),
      .out_stall (b_stall),
      .out_quot  (b_quot),
      .out_rem   (b_rem),
      .out_side  (b_side_out)
   );

   // hue assembly, mode select, inversion and output register
   rhc_post #(
      .PWM_MAX (PWM_MAX)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .inverted   (inverted_ff),
      .in_valid   (b_valid),
      .in_stall   (b_stall),
      .in_quot    ({b_val, b_quot}),
      .in_hue_rem (b_rem[0]),
      .in_lvl     (b_lvl),
      .in_term    (b_term),
      .in_ctl     (b_ctl),
      .in_hsv     (b_hsv),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transfer changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_q12_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sat_out <= Q12_ONE) && (rsp_data.val_out <= Q12_ONE))
      else $error("saturation or value above one");
`endif

endmodule

// ----- tb/rgb_hsv_led_color_converter_checker.sv -----
`timescale 1ns / 1ps

module rgb_hsv_led_color_converter_checker import rhc_pkg::*; #(
   parameter int PWM_MAX = 1023
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_type      req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic         pready,
   output int           fail_count,
   output int           colors_pending
);

   localparam logic [2:0] ADDR_INVERTED = 3'd0;

   rsp_type color_queue[$];
   logic    led_inverted;

   function automatic rsp_type convert_color(req_type rq, logic inv);
      rsp_type          rs;
      longint           r, g, b, mx, mn, d, num, hue;
      longint unsigned  s, v, h, fr, one60, den, tv, tp, tq, tt;
      int               sector;
      if (rq.mode == MODE_RGB) begin
         r = rq.red_in % (PWM_MAX + 1);
         g = rq.green_in % (PWM_MAX + 1);
         b = rq.blue_in % (PWM_MAX + 1);
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         hue = 0;
         if (d != 0) begin
            if (mx == r) num = 60 * (g - b);
            else if (mx == g) num = 120 * d + 60 * (b - r);
            else num = 240 * d + 60 * (r - g);
            // signed division truncates toward zero
            hue = num / d;
            if (hue < 0) hue += 360;
         end
         rs.hue_out = hue;
         rs.sat_out = (mx == 0) ? 0 : (d * 4096) / mx;
         rs.val_out = (mx * 4096) / PWM_MAX;
      end else begin
         s = (rq.sat_in > 4096) ? 4096 : rq.sat_in;
         v = (rq.val_in > 4096) ? 4096 : rq.val_in;
         h = rq.hue_in % 360;
         sector = h / 60;
         fr = h % 60;
         one60 = 60 * 4096;
         den = one60 * 4096;
         tv = (v * one60 * PWM_MAX) / den;
         tp = (v * (4096 - s) * 60 * PWM_MAX) / den;
         tq = (v * (one60 - s * fr) * PWM_MAX) / den;
         tt = (v * (one60 - s * (60 - fr)) * PWM_MAX) / den;
         case (sector)
            0: begin r = tv; g = tt; b = tp; end
            1: begin r = tq; g = tv; b = tp; end
            2: begin r = tp; g = tv; b = tt; end
            3: begin r = tp; g = tq; b = tv; end
            4: begin r = tt; g = tp; b = tv; end
            default: begin r = tv; g = tp; b = tq; end
         endcase
         rs.hue_out = rq.hue_in;
         rs.sat_out = s;
         rs.val_out = v;
      end
      rs.level_red   = r;
      rs.level_green = g;
      rs.level_blue  = b;
      rs.drive_red   = inv ? PWM_MAX - r : r;
      rs.drive_green = inv ? PWM_MAX - g : g;
      rs.drive_blue  = inv ? PWM_MAX - b : b;
      return rs;
   endfunction

   task automatic check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   assign colors_pending = color_queue.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         led_inverted <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_INVERTED)
            led_inverted <= pwdata[0];
         if (req_valid && !req_stall)
            color_queue.push_back(convert_color(req_data, led_inverted));
         if (rsp_valid && !rsp_stall) begin
            if (color_queue.size() == 0) begin
               $error("color transfer with none expected");
               fail_count++;
            end else begin
               want = color_queue.pop_front();
               check_field("level_red", want.level_red, rsp_data.level_red);
               check_field("level_green", want.level_green, rsp_data.level_green);
               check_field("level_blue", want.level_blue, rsp_data.level_blue);
               check_field("hue_out", want.hue_out, rsp_data.hue_out);
               check_field("sat_out", want.sat_out, rsp_data.sat_out);
               check_field("val_out", want.val_out, rsp_data.val_out);
               check_field("drive_red", want.drive_red, rsp_data.drive_red);
               check_field("drive_green", want.drive_green, rsp_data.drive_green);
               check_field("drive_blue", want.drive_blue, rsp_data.drive_blue);
            end
         end
      end
   end

endmodule

// ----- tb/rgb_hsv_led_color_converter_tb.sv -----
`timescale 1ns / 1ps

module rgb_hsv_led_color_converter_tb;
   import rhc_pkg::*;

   localparam logic [2:0] ADDR_INVERTED = 3'd0;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PIPE_DRAIN  = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type      req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type      rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int fail_count;
   int colors_pending;
   int cycle_count = 0;
   // when set, both sides run back to back with no gaps
   logic no_gaps = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb_hsv_led_color_converter u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   rgb_hsv_led_color_converter_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .colors_pending
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rgb_hsv_led_color_converter_tb: FAIL");
         $finish;
      end
   end

   // result side: random stall before each transfer, then hold off until it lands
   always begin
      int n;
      logic got;
      n = no_gaps ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
      end
      rsp_stall <= 1'b0;
      do begin
         @(negedge clock);
         got = rsp_valid;
         @(posedge clock);
      end while (!got);
   end

   // one register write: setup then access cycle
   task automatic write_inverted(logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_INVERTED; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // wait for the pipe to drain before touching the register
   task automatic wait_idle();
      while (colors_pending != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // present one color request; returns on the edge of its transfer
   task automatic send_color(req_type item);
      int gap;
      logic taken;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic req_type rgb_color(int r, int g, int b);
      req_type q;
      q = '0;
      q.mode = MODE_RGB;
      q.red_in = r; q.green_in = g; q.blue_in = b;
      q.hue_in = $urandom; q.sat_in = $urandom; q.val_in = $urandom;
      return q;
   endfunction

   function automatic req_type hsv_color(int h, int s, int v);
      req_type q;
      q = '0;
      q.mode = MODE_HSV;
      q.hue_in = h; q.sat_in = s; q.val_in = v;
      q.red_in = $urandom; q.green_in = $urandom; q.blue_in = $urandom;
      return q;
   endfunction

   function automatic req_type random_color();
      req_type q;
      q = req_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 3))
         // levels inside the PWM range, often with ties
         0: begin
            q.red_in = $urandom_range(0, 1023);
            q.green_in = ($urandom_range(0, 3) == 0) ? q.red_in : $urandom_range(0, 1023);
            q.blue_in = $urandom_range(0, 1023);
         end
         // in-range hsv with saturation and value up to one
         1: begin
            q.hue_in = $urandom_range(0, 359);
            q.sat_in = $urandom_range(0, 4096);
            q.val_in = $urandom_range(0, 4096);
         end
         default: ;
      endcase
      return q;
   endfunction

   initial begin
      req_type dir[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_inverted(32'd0);

      // directed: rgb extremes, gray, wrap of the reduction, each max channel
      dir.push_back(rgb_color(0, 0, 0));
      dir.push_back(rgb_color(1023, 1023, 1023));
      dir.push_back(rgb_color(16'hffff, 16'hffff, 16'hffff));
      dir.push_back(rgb_color(1024, 1024, 1024));
      dir.push_back(rgb_color(1023, 0, 500));    // red max, hue wraps negative
      dir.push_back(rgb_color(900, 0, 0));
      dir.push_back(rgb_color(10, 800, 300));
      dir.push_back(rgb_color(700, 100, 1000));
      dir.push_back(rgb_color(600, 600, 20));    // red and green tie
      dir.push_back(rgb_color(5, 900, 900));     // green and blue tie
      // directed: hsv sector edges, hue wrap, clamps, zero terms
      dir.push_back(hsv_color(0, 4096, 4096));
      dir.push_back(hsv_color(59, 4096, 4096));
      dir.push_back(hsv_color(60, 2048, 4096));
      dir.push_back(hsv_color(119, 4096, 3000));
      dir.push_back(hsv_color(180, 4096, 4096));
      dir.push_back(hsv_color(240, 1000, 4096));
      dir.push_back(hsv_color(300, 4096, 4096));
      dir.push_back(hsv_color(359, 4096, 4096));
      dir.push_back(hsv_color(360, 4096, 4096));
      dir.push_back(hsv_color(16'hffff, 13'h1fff, 13'h1fff));
      dir.push_back(hsv_color(200, 0, 4096));
      dir.push_back(hsv_color(100, 4096, 0));
      foreach (dir[i]) send_color(dir[i]);

      // random phases, the register toggled between them
      for (int phase = 0; phase < 4; phase++) begin
         req_valid <= 1'b0;
         wait_idle();
         write_inverted({31'($urandom), 1'b0} | ((phase % 2 == 0) ? 32'd1 : 32'd0));
         for (int k = 0; k < 370; k++) begin
            if (k % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_color(random_color());
         end
         no_gaps = 1'b0;
      end
      req_valid <= 1'b0;

      wait_idle();
      if (fail_count == 0) begin
         $display("rgb_hsv_led_color_converter_tb: PASS");
      end else begin
         $display("rgb_hsv_led_color_converter_tb: FAIL");
      end
      $finish;
   end

endmodule
